// File: hw/rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Types, constants and register codes shared by the midpoint circle
// rasterizer and its step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

   // coordinate width of the ports and default internal coordinate width
   localparam int OUT_W          = 16;
   localparam int COORD_BITS_DEF = 16;

   // radius field and loop limits
   localparam int RAD_W      = 7;
   localparam int MAX_RADIUS = 88;
   localparam int STEP_CAP   = 64;
   localparam int CNT_W      = $clog2(STEP_CAP + 1);

   // decision variable: stays well inside +-1024 for radii up to 127
   localparam int D_W       = 12;
   localparam int D_INIT    = 3;
   localparam int D_INC_LO  = 6;
   localparam int D_INC_HI  = 10;

   // clip compare width: 16 bit edge plus 15 bit extent, signed
   localparam int CMP_W     = 18;
   localparam int CLIP_W    = 16;
   localparam int EXTENT_W  = 15;

   localparam logic [EXTENT_W-1:0] CLIP_WIDTH_RST  = 15'd4096;
   localparam logic [EXTENT_W-1:0] CLIP_HEIGHT_RST = 15'd4096;

   typedef enum logic [1:0] {
      CSR_CLIP_LEFT   = 2'd0,
      CSR_CLIP_TOP    = 2'd1,
      CSR_CLIP_WIDTH  = 2'd2,
      CSR_CLIP_HEIGHT = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] center_x;
      logic signed [OUT_W-1:0] center_y;
      logic [RAD_W-1:0]        radius;
      logic                    fill_mode;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x_plus_near;
      logic signed [OUT_W-1:0] x_minus_near;
      logic signed [OUT_W-1:0] x_plus_far;
      logic signed [OUT_W-1:0] x_minus_far;
      logic signed [OUT_W-1:0] y_plus_near;
      logic signed [OUT_W-1:0] y_minus_near;
      logic signed [OUT_W-1:0] y_plus_far;
      logic signed [OUT_W-1:0] y_minus_far;
      logic                    bbox_in_clip;
      logic                    last_step;
   } rsp_type;

   // iteration state handed between sequencer and step unit
   typedef struct packed {
      logic [RAD_W-1:0]        x;
      logic [RAD_W-1:0]        y;
      logic signed [D_W-1:0]   d;
   } iter_type;

endpackage

`default_nettype wire

// File: hw/rtl/mcr_step_unit.sv
// ----------------------------------------------------------------------------
// mcr_step_unit
// One midpoint circle iteration: mirrors the current (x, y) around the
// center into eight coordinates and advances the decision variable.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_step_unit #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0]    cx,
   input  logic [COORD_BITS-1:0]    cy,
   input  mcr_pkg::iter_type        iter_cur,
   input  logic [mcr_pkg::CNT_W-1:0] cnt_val,
   input  logic                     box_in,
   output mcr_pkg::iter_type        iter_nxt,
   output mcr_pkg::rsp_type         rsp
);
   import mcr_pkg::*;

   logic signed [D_W-1:0]  x_d;
   logic signed [D_W-1:0]  y_d;
   logic signed [D_W-1:0]  d_lo;
   logic signed [D_W-1:0]  d_hi;
   logic [COORD_BITS-1:0]  x_c;
   logic [COORD_BITS-1:0]  y_c;
   logic [COORD_BITS-1:0]  cx_pn, cx_mn, cx_pf, cx_mf;
   logic [COORD_BITS-1:0]  cy_pn, cy_mn, cy_pf, cy_mf;
   logic [CNT_W-1:0]       cnt_nxt;

   assign x_d = signed'(D_W'(iter_cur.x));
   assign y_d = signed'(D_W'(iter_cur.y));

   assign d_lo = iter_cur.d + (x_d <<< 2) + signed'(D_W'(D_INC_LO));
   assign d_hi = iter_cur.d + ((x_d - y_d) <<< 2) + signed'(D_W'(D_INC_HI));

   always_comb begin
      iter_nxt.x = iter_cur.x + 1'b1;
      if (iter_cur.d[D_W-1]) begin
         iter_nxt.y = iter_cur.y;
         iter_nxt.d = d_lo;
      end else begin
         iter_nxt.y = iter_cur.y - 1'b1;
         iter_nxt.d = d_hi;
      end
   end

   // coordinates wrap at COORD_BITS, then sign extend to the port width
   assign x_c   = COORD_BITS'(iter_cur.x);
   assign y_c   = COORD_BITS'(iter_cur.y);
   assign cx_pn = cx + x_c;
   assign cx_mn = cx - x_c;
   assign cx_pf = cx + y_c;
   assign cx_mf = cx - y_c;
   assign cy_pn = cy + x_c;
   assign cy_mn = cy - x_c;
   assign cy_pf = cy + y_c;
   assign cy_mf = cy - y_c;

   assign cnt_nxt = CNT_W'(cnt_val + 1'b1);

   always_comb begin
      rsp.x_plus_near  = OUT_W'(signed'(cx_pn));
      rsp.x_minus_near = OUT_W'(signed'(cx_mn));
      rsp.x_plus_far   = OUT_W'(signed'(cx_pf));
      rsp.x_minus_far  = OUT_W'(signed'(cx_mf));
      rsp.y_plus_near  = OUT_W'(signed'(cy_pn));
      rsp.y_minus_near = OUT_W'(signed'(cy_mn));
      rsp.y_plus_far   = OUT_W'(signed'(cy_pf));
      rsp.y_minus_far  = OUT_W'(signed'(cy_mf));
      rsp.bbox_in_clip = box_in;
      rsp.last_step    = (iter_nxt.x > iter_nxt.y) || (cnt_nxt == CNT_W'(STEP_CAP));
   end

endmodule

`default_nettype wire

// File: hw/rtl/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Bresenham midpoint circle stepper with radius and bounding-box reject
// against a programmable clip rectangle; one mirrored result per iteration.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  handshake
//  command   start, busy, req_data          in         start & !busy
//  result    rsp_valid, rsp_data            out        one-cycle strobe
//  csr       csr_we, csr_addr, csr_wdata    in         write on csr_we
//
//  a command is set up (capture, then clip test) and then runs its iteration
//  steps through the shared step unit, up to 64 steps (STEP_CAP)
//  a rejected command gives no result
//  busy goes high after the transfer and stays high until the cycle after
//  the last step; results cannot be stalled; reset is synchronous and clears
//  the sequencer and the clip registers, no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mcr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output mcr_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  mcr_pkg::csr_idx_type            csr_addr,
   input  logic [mcr_pkg::CLIP_W-1:0]      csr_wdata
);
   import mcr_pkg::*;

   state_type                   state_ff, state_in;
   logic [COORD_BITS-1:0]       cx_ff, cx_in;
   logic [COORD_BITS-1:0]       cy_ff, cy_in;
   logic [RAD_W-1:0]            r_ff, r_in;
   logic                        fill_ff, fill_in;
   logic                        inside_ff, inside_in;
   iter_type                    iter_ff, iter_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   rsp_type                     rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic signed [CLIP_W-1:0]    clip_left_ff, clip_left_in;
   logic signed [CLIP_W-1:0]    clip_top_ff, clip_top_in;
   logic [EXTENT_W-1:0]         clip_width_ff, clip_width_in;
   logic [EXTENT_W-1:0]         clip_height_ff, clip_height_in;

   logic                        accept;
   logic [COORD_BITS-1:0]       r_c;
   logic [COORD_BITS-1:0]       x1, x2, y1, y2;
   logic signed [CMP_W-1:0]     x1_s, x2_s, y1_s, y2_s;
   logic signed [CMP_W-1:0]     left_s, top_s, right_s, bottom_s;
   logic                        bad_radius, outside, all_inside;
   iter_type                    iter_step;
   rsp_type                     rsp_step;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // bounding box vs clip rectangle: corners wrap, clip edge sums do not
   assign r_c      = COORD_BITS'(r_ff);
   assign x1       = cx_ff - r_c;
   assign x2       = cx_ff + r_c;
   assign y1       = cy_ff - r_c;
   assign y2       = cy_ff + r_c;
   assign x1_s     = CMP_W'(signed'(x1));
   assign x2_s     = CMP_W'(signed'(x2));
   assign y1_s     = CMP_W'(signed'(y1));
   assign y2_s     = CMP_W'(signed'(y2));
   assign left_s   = CMP_W'(clip_left_ff);
   assign top_s    = CMP_W'(clip_top_ff);
   assign right_s  = left_s + signed'(CMP_W'(clip_width_ff));
   assign bottom_s = top_s + signed'(CMP_W'(clip_height_ff));

   assign bad_radius = (r_ff == '0) || (r_ff > RAD_W'(MAX_RADIUS));
   assign outside    = (x2_s < left_s) || (x1_s >= right_s) ||
                       (y2_s < top_s) || (y1_s >= bottom_s);
   assign all_inside = !fill_ff && (x1_s >= left_s) && (y1_s >= top_s) &&
                       (x2_s < right_s) && (y2_s < bottom_s);

   mcr_step_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .cx       (cx_ff),
      .cy       (cy_ff),
      .iter_cur (iter_ff),
      .cnt_val  (cnt_ff),
      .box_in   (inside_ff),
      .iter_nxt (iter_step),
      .rsp      (rsp_step)
   );

   always_comb begin
      state_in       = state_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      r_in           = r_ff;
      fill_in        = fill_ff;
      inside_in      = inside_ff;
      iter_in        = iter_ff;
      cnt_in         = cnt_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = 1'b0;
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_width_in  = clip_width_ff;
      clip_height_in = clip_height_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_CLIP_LEFT:   clip_left_in   = signed'(csr_wdata);
            CSR_CLIP_TOP:    clip_top_in    = signed'(csr_wdata);
            CSR_CLIP_WIDTH:  clip_width_in  = csr_wdata[EXTENT_W-1:0];
            CSR_CLIP_HEIGHT: clip_height_in = csr_wdata[EXTENT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cx_in    = req_data.center_x[COORD_BITS-1:0];
               cy_in    = req_data.center_y[COORD_BITS-1:0];
               r_in     = req_data.radius;
               fill_in  = req_data.fill_mode;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            inside_in = all_inside;
            iter_in.x = '0;
            iter_in.y = r_ff;
            iter_in.d = signed'(D_W'(D_INIT)) - (signed'(D_W'(r_ff)) <<< 1);
            cnt_in    = '0;
            if (bad_radius || outside) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            rsp_in       = rsp_step;
            rsp_valid_in = 1'b1;
            iter_in      = iter_step;
            cnt_in       = CNT_W'(cnt_ff + 1'b1);
            if (rsp_step.last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= CLIP_WIDTH_RST;
         clip_height_ff <= CLIP_HEIGHT_RST;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         clip_left_ff   <= clip_left_in;
         clip_top_ff    <= clip_top_in;
         clip_width_ff  <= clip_width_in;
         clip_height_ff <= clip_height_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      r_ff      <= r_in;
      fill_ff   <= fill_in;
      inside_ff <= inside_in;
      iter_ff   <= iter_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   // a result only follows a step cycle
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_STEP))
      else $error("result strobe without a step cycle");

   // a command transfer makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after command transfer");

   // the last step of a circle hands control back to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_step) |-> (state_ff == ST_IDLE))
      else $error("sequencer still running after last step");

   // fill mode never reports the box in the clip
   a_fill_not_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(fill_ff && rsp_ff.bbox_in_clip))
      else $error("box in clip flag set in fill mode");

   // the step count never runs past the cap
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (cnt_ff < CNT_W'(STEP_CAP)))
      else $error("step count beyond cap");

endmodule

`default_nettype wire

// File: tb/tb_midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_midpoint_circle_rasterizer
// Self-checking bench for the midpoint circle rasterizer. Circle commands are
// queued by the stimulus process and handed to the block by a clocked driver
// with random gaps. A clocked monitor traces each accepted circle against the
// clip rectangle mirror and checks every step result field by field. The clip
// registers are changed between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   import mcr_pkg::*;

   localparam int RSP_W       = $bits(rsp_type);
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      req_type cmd;
      bit      drain;
   } pending_circle;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   csr_idx_type         csr_addr = CSR_CLIP_LEFT;
   logic [CLIP_W-1:0]   csr_wdata = '0;

   pending_circle circle_cmds[$];
   rsp_type       expected_steps[$];

   // clip rectangle as the block should hold it
   int  clip_left, clip_top, clip_width, clip_height;
   int  error_count = 0;
   int  cycle_count = 0;
   int  gap_left = 0;
   int  burst_left = 0;
   bit  cmd_taken = 1'b0;

   string coord_name [8] = '{"x_plus_near", "x_minus_near", "x_plus_far", "x_minus_far",
                             "y_plus_near", "y_minus_near", "y_plus_far", "y_minus_far"};

   midpoint_circle_rasterizer uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int wrap16(int v);
      return $signed(v[15:0]);
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // radius and bounding-box reject, then one entry per midpoint step
   function automatic void trace_circle(req_type c);
      int cx, cy, r, x, y, d, x1, x2, y1, y2, n;
      bit in_clip;
      rsp_type s;
      cx = c.center_x;
      cy = c.center_y;
      r  = c.radius;
      if (r == 0 || r > MAX_RADIUS) return;
      x1 = wrap16(cx - r);
      x2 = wrap16(cx + r);
      y1 = wrap16(cy - r);
      y2 = wrap16(cy + r);
      if (x2 < clip_left || x1 >= clip_left + clip_width) return;
      if (y2 < clip_top || y1 >= clip_top + clip_height) return;
      in_clip = !c.fill_mode && x1 >= clip_left && y1 >= clip_top &&
                x2 < clip_left + clip_width && y2 < clip_top + clip_height;
      x = 0;
      y = r;
      d = D_INIT - 2 * r;
      n = 0;
      while (x <= y && n < STEP_CAP) begin
         s.x_plus_near  = 16'(cx + x);
         s.x_minus_near = 16'(cx - x);
         s.x_plus_far   = 16'(cx + y);
         s.x_minus_far  = 16'(cx - y);
         s.y_plus_near  = 16'(cy + x);
         s.y_minus_near = 16'(cy - x);
         s.y_plus_far   = 16'(cy + y);
         s.y_minus_far  = 16'(cy - y);
         s.bbox_in_clip = in_clip;
         if (d < 0) begin
            d = d + 4 * x + D_INC_LO;
         end else begin
            d = d + 4 * (x - y) + D_INC_HI;
            y--;
         end
         x++;
         n++;
         s.last_step = (x > y || n == STEP_CAP);
         expected_steps.push_back(s);
      end
   endfunction

   // monitor: results first, then register writes and command transfers
   always @(posedge clock) begin : monitor
      rsp_type want;
      logic [RSP_W-1:0] got_bits, want_bits;
      cmd_taken = 1'b0;
      if (reset) begin
         clip_left   = 0;
         clip_top    = 0;
         clip_width  = CLIP_WIDTH_RST;
         clip_height = CLIP_HEIGHT_RST;
      end else begin
         if (rsp_valid) begin
            if (expected_steps.size() == 0) begin
               flag_mismatch($sformatf("result %h with none expected", rsp_data));
            end else begin
               want = expected_steps.pop_front();
               got_bits  = rsp_data;
               want_bits = want;
               for (int k = 0; k < 8; k++) begin
                  if (got_bits[RSP_W-1-16*k -: 16] !== want_bits[RSP_W-1-16*k -: 16])
                     flag_mismatch($sformatf("%s got %0d want %0d", coord_name[k],
                                   $signed(got_bits[RSP_W-1-16*k -: 16]),
                                   $signed(want_bits[RSP_W-1-16*k -: 16])));
               end
               if (rsp_data.bbox_in_clip !== want.bbox_in_clip)
                  flag_mismatch($sformatf("bbox_in_clip got %b want %b",
                                rsp_data.bbox_in_clip, want.bbox_in_clip));
               if (rsp_data.last_step !== want.last_step)
                  flag_mismatch($sformatf("last_step got %b want %b",
                                rsp_data.last_step, want.last_step));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_CLIP_LEFT:   clip_left   = $signed(csr_wdata);
               CSR_CLIP_TOP:    clip_top    = $signed(csr_wdata);
               CSR_CLIP_WIDTH:  clip_width  = csr_wdata[EXTENT_W-1:0];
               CSR_CLIP_HEIGHT: clip_height = csr_wdata[EXTENT_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            cmd_taken = 1'b1;
            trace_circle(req_data);
         end
      end
   end

   // driver: holds start until the transfer, then idles for a random gap
   always @(negedge clock) begin
      int pick;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !cmd_taken)) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (circle_cmds.size() != 0 &&
                      !(circle_cmds[0].drain && (expected_steps.size() != 0 || busy))) begin
            req_data <= circle_cmds[0].cmd;
            start    <= 1'b1;
            circle_cmds.pop_front();
            pick = $urandom_range(0, 99);
            if (burst_left > 0) begin
               burst_left--;
               gap_left = 0;
            end else if (pick < 15) begin
               burst_left = $urandom_range(5, 20);
               gap_left   = 0;
            end else if (pick < 75) begin
               gap_left = $urandom_range(0, 3);
            end else if (pick < 92) begin
               gap_left = $urandom_range(4, 12);
            end else begin
               gap_left = $urandom_range(20, 90);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** midpoint_circle_rasterizer: FAILED **");
         $finish;
      end
   end

   task automatic queue_circle(int cx, int cy, int r, bit fill, bit drain = 1'b0);
      pending_circle p;
      p.cmd.center_x  = 16'(cx);
      p.cmd.center_y  = 16'(cy);
      p.cmd.radius    = 7'(r);
      p.cmd.fill_mode = fill;
      p.drain         = drain;
      circle_cmds.push_back(p);
   endtask

   // centers mostly around the clip rectangle and its edges, some anywhere
   task automatic queue_random_circles(int count);
      int r, sel, edge_pos, cx, cy;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 70)      r = $urandom_range(1, 24);
         else if (sel < 90) r = $urandom_range(25, MAX_RADIUS);
         else if (sel < 95) r = $urandom_range(0, 1) ? 0 : MAX_RADIUS;
         else               r = $urandom_range(MAX_RADIUS + 1, 127);
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            cx = clip_left - r - 4 + int'($urandom_range(0, clip_width + 2 * r + 8));
            cy = clip_top - r - 4 + int'($urandom_range(0, clip_height + 2 * r + 8));
         end else if (sel < 85) begin
            edge_pos = $urandom_range(0, 1) ? clip_left : clip_left + clip_width;
            cx = edge_pos - r - 1 + int'($urandom_range(0, 2 * r + 2));
            edge_pos = $urandom_range(0, 1) ? clip_top : clip_top + clip_height;
            cy = edge_pos - r - 1 + int'($urandom_range(0, 2 * r + 2));
         end else begin
            cx = $urandom_range(0, 65535);
            cy = $urandom_range(0, 65535);
         end
         queue_circle(cx, cy, r, $urandom_range(0, 1), $urandom_range(0, 99) < 5);
      end
   endtask

   // wait for the block to drain; a rejected circle gives no result
   task automatic settle();
      do @(posedge clock);
      while (circle_cmds.size() != 0 || start || busy || expected_steps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clip(csr_idx_type idx, int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= 16'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_clip(int left, int top, int width, int height);
      write_clip(CSR_CLIP_LEFT, left);
      write_clip(CSR_CLIP_TOP, top);
      write_clip(CSR_CLIP_WIDTH, width);
      write_clip(CSR_CLIP_HEIGHT, height);
      @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset clip of 0,0 and 4096 by 4096
      queue_circle(100, 100, 1, 1'b0);
      queue_circle(1000, 1000, MAX_RADIUS, 1'b1);
      queue_circle(1000, 1000, MAX_RADIUS, 1'b0);
      queue_circle(500, 500, 0, 1'b0);
      queue_circle(500, 500, MAX_RADIUS + 1, 1'b0);
      queue_circle(500, 500, 127, 1'b1);
      queue_circle(0, 0, 5, 1'b0);
      queue_circle(-6, 100, 5, 1'b0);
      queue_circle(-5, 100, 5, 1'b1);
      queue_circle(4101, 100, 5, 1'b0);
      queue_circle(4100, 100, 5, 1'b0);
      queue_circle(100, -6, 5, 1'b0);
      queue_circle(100, -5, 5, 1'b0);
      queue_circle(100, 4101, 5, 1'b1);
      queue_circle(100, 4100, 5, 1'b0);
      queue_circle(4090, 4090, 5, 1'b0);
      queue_circle(32767, 32767, 10, 1'b0);
      queue_circle(-32768, -32768, 3, 1'b1);
      queue_circle(2000, 3000, 2, 1'b0, 1'b1);
      queue_circle(2000, 3000, 3, 1'b1);
      queue_circle(-1, -1, 64, 1'b0);
      settle();

      set_clip(-100, -50, 400, 300);
      queue_random_circles(40);
      settle();

      set_clip(-32768, -32768, 16'h7fff, 16'h7fff);
      queue_random_circles(20);
      settle();

      // zero width or height: only boxes across the left or top edge get through
      set_clip(0, 0, 0, 100);
      queue_random_circles(8);
      settle();
      set_clip(0, 0, 100, 0);
      queue_random_circles(6);
      settle();

      // extent bit 15 is not stored
      set_clip(32767, 32767, 16'h8000 | 50, 16'hffff);
      queue_circle(32767 - 20, 32767 - 20, 20, 1'b0);
      queue_random_circles(8);
      settle();

      for (int p = 0; p < 3; p++) begin
         set_clip(int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000,
                  $urandom_range(1, 3000) | ($urandom_range(0, 1) << 15),
                  $urandom_range(1, 3000) | ($urandom_range(0, 1) << 15));
         queue_random_circles(20);
         settle();
      end

      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("** midpoint_circle_rasterizer: PASSED **");
      end else begin
         $display("** midpoint_circle_rasterizer: FAILED **");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/mcr_pkg.sv
hw/rtl/mcr_step_unit.sv
hw/rtl/midpoint_circle_rasterizer.sv
tb/tb_midpoint_circle_rasterizer.sv
